// ----- rtl/core/pwr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pwr_pkg;

	// reset value of the placement distance, Q16.16
	localparam logic [30:0] RD_RESET = 31'd655;
	// 1.0 in Q16.16 as a 17-bit proportion
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// per-item fields carried alongside the long arithmetic
	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic signed [31:0] st;
		logic signed [31:0] sl;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic               dxn;
		logic               dyn;
		logic [31:0]        magx;
		logic [31:0]        magy;
		logic [30:0]        rd;
		logic               tsh;
		logic               fsh;
	} carry_t;

	// decisions made once both distances are known
	typedef struct packed {
		logic short_move;
		logic use_ratio;
	} late_t;

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pwr_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// pipelined integer square root, one result bit per stage
module pwr_isqrt #(
	parameter int IN_W = 64
) (
	input  wire logic                clk,
	input  wire logic [IN_W-1:0]     din,
	output logic      [IN_W/2-1:0]   root
);

	localparam int N = IN_W / 2;

	logic [IN_W-1:0] v_q  [N];
	logic [IN_W-1:0] r_q  [N];
	logic [IN_W-1:0] v_in [N];
	logic [IN_W-1:0] r_in [N];

	assign v_in[0] = din;
	assign r_in[0] = '0;

	genvar i;
	generate
		for (i = 1; i < N; i++) begin : g_link
			assign v_in[i] = v_q[i-1];
			assign r_in[i] = r_q[i-1];
		end
		for (i = 0; i < N; i++) begin : g_stage
			localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * i);
			logic [IN_W:0] sum;
			logic          ge;
			// trial subtract of the next root bit
			always_comb begin
				sum = {1'b0, r_in[i]} + {1'b0, BIT};
				ge  = {1'b0, v_in[i]} >= sum;
			end
			always_ff @(posedge clk) begin
				if (ge) begin
					v_q[i] <= IN_W'({1'b0, v_in[i]} - sum);
					r_q[i] <= (r_in[i] >> 1) + BIT;
				end else begin
					v_q[i] <= v_in[i];
					r_q[i] <= r_in[i] >> 1;
				end
			end
		end
	endgenerate

	assign root = r_q[N-1][N-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/pwr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
module pwr_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 33,
	parameter int Q_W   = 32
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_q  [Q_W];
	logic [Q_W-1:0]   lo_q   [Q_W];
	logic [Q_W-1:0]   q_q    [Q_W];
	logic [DEN_W-1:0] den_q  [Q_W];
	logic [DEN_W-1:0] rem_in [Q_W];
	logic [Q_W-1:0]   lo_in  [Q_W];
	logic [Q_W-1:0]   q_in   [Q_W];
	logic [DEN_W-1:0] den_in [Q_W];

	assign rem_in[0] = DEN_W'(num[NUM_W-1:Q_W]);
	assign lo_in[0]  = num[Q_W-1:0];
	assign q_in[0]   = '0;
	assign den_in[0] = den;

	genvar i;
	generate
		for (i = 1; i < Q_W; i++) begin : g_link
			assign rem_in[i] = rem_q[i-1];
			assign lo_in[i]  = lo_q[i-1];
			assign q_in[i]   = q_q[i-1];
			assign den_in[i] = den_q[i-1];
		end
		for (i = 0; i < Q_W; i++) begin : g_stage
			logic [DEN_W:0] trial;
			logic           ge;
			// shift in the next numerator bit and try the subtract
			always_comb begin
				trial = {rem_in[i], lo_in[i][Q_W-1]};
				ge    = trial >= {1'b0, den_in[i]};
			end
			always_ff @(posedge clk) begin
				rem_q[i] <= ge ? DEN_W'(trial - {1'b0, den_in[i]}) : trial[DEN_W-1:0];
				lo_q[i]  <= lo_in[i] << 1;
				q_q[i]   <= {q_in[i][Q_W-2:0], ge};
				den_q[i] <= den_in[i];
			end
		end
	endgenerate

	assign quo = q_q[Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/particle_wall_reflection_2d.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Wall reflection of one 2D particle per item, fixed point.
// Input: drive the particle fields and pulse start; an item is taken at
// each edge where start is high and busy is low. busy is always low, so
// one item can enter every clock cycle with no gaps.
// Output: done is high for one cycle with the corrected position, the
// reflected velocity and the adjusted step values of one item, in the
// order the items arrived. The receiver cannot hold results off and the
// block never needs it to.
// The path runs through the chain distance root (32 stages), the placement
// divider (32 stages) and the arithmetic stages around them; the step
// proportion runs in parallel through a 16-stage divider and root.
// standoff is written with standoff_we; the user must do it only while no
// item is in flight, as the block does not enforce it. Reset (arst_n low)
// clears the pipeline valid bits, sets standoff to 655 and drops earlier items.
module particle_wall_reflection_2d (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               standoff_we,
	input  wire logic [30:0]        standoff,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] prev_x,
	input  wire logic signed [31:0] prev_y,
	input  wire logic signed [31:0] hit_x,
	input  wire logic signed [31:0] hit_y,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [31:0] step_total,
	input  wire logic signed [31:0] step_last,
	output logic                    done,
	output logic signed [31:0]      new_pos_x,
	output logic signed [31:0]      new_pos_y,
	output logic signed [31:0]      new_vel_x,
	output logic signed [31:0]      new_vel_y,
	output logic signed [31:0]      new_step_total,
	output logic signed [31:0]      new_step_last
);

	import pwr_pkg::*;

	localparam int LAT     = 72;
	localparam int CARRY_N = 70;
	localparam int NV_N    = 67;
	localparam int LATE_N  = 34;

	logic [30:0] rd_q;
	logic        vld_q [LAT];

	assign busy = 1'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= RD_RESET;
		end else if (standoff_we) begin
			rd_q <= standoff;
		end
	end

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start & ~busy;
			for (int k = 1; k < LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign done = vld_q[LAT-1];

	// stage 1: differences, magnitudes, dot product terms
	logic signed [32:0] dx_c, dy_c, fx_c, fy_c;
	logic [32:0]        adx_c, ady_c, afx_c, afy_c;
	logic               tsh_c, fsh_c;

	always_comb begin
		dx_c  = 33'(prev_x) - 33'(hit_x);
		dy_c  = 33'(prev_y) - 33'(hit_y);
		fx_c  = 33'(pos_x) - 33'(prev_x);
		fy_c  = 33'(pos_y) - 33'(prev_y);
		adx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
		ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
		afx_c = fx_c[32] ? 33'(-fx_c) : 33'(fx_c);
		afy_c = fy_c[32] ? 33'(-fy_c) : 33'(fy_c);
		tsh_c = adx_c[31] | ady_c[31];
		fsh_c = afx_c[31] | afy_c[31];
	end

	carry_t             carry_s1;
	logic signed [47:0] prodx_s1, prody_s1;
	logic [30:0]        ta_s1, tb_s1, fa_s1, fb_s1;
	carry_t             carry_q [CARRY_N];

	always_ff @(posedge clk) begin
		carry_s1.vx   <= vel_x;
		carry_s1.vy   <= vel_y;
		carry_s1.qx   <= prev_x;
		carry_s1.qy   <= prev_y;
		carry_s1.hx   <= hit_x;
		carry_s1.hy   <= hit_y;
		carry_s1.st   <= step_total;
		carry_s1.sl   <= step_last;
		carry_s1.nx   <= normal_x;
		carry_s1.ny   <= normal_y;
		carry_s1.dxn  <= dx_c[32];
		carry_s1.dyn  <= dy_c[32];
		carry_s1.magx <= adx_c[31:0];
		carry_s1.magy <= ady_c[31:0];
		carry_s1.rd   <= rd_q;
		carry_s1.tsh  <= tsh_c;
		carry_s1.fsh  <= fsh_c;
		prodx_s1      <= 48'(normal_x) * 48'(vel_x);
		prody_s1      <= 48'(normal_y) * 48'(vel_y);
		ta_s1         <= tsh_c ? adx_c[31:1] : adx_c[30:0];
		tb_s1         <= tsh_c ? ady_c[31:1] : ady_c[30:0];
		fa_s1         <= fsh_c ? afx_c[31:1] : afx_c[30:0];
		fb_s1         <= fsh_c ? afy_c[31:1] : afy_c[30:0];
	end

	// carried fields, entry k holds stage k + 2
	always_ff @(posedge clk) begin
		carry_q[0] <= carry_s1;
		for (int k = 1; k < CARRY_N; k++) begin
			carry_q[k] <= carry_q[k-1];
		end
	end

	// stage 2: dot product and squares
	logic signed [48:0] dot_s2;
	logic [61:0]        ta2_s2, tb2_s2, fa2_s2, fb2_s2;

	always_ff @(posedge clk) begin
		dot_s2 <= 49'(prodx_s1) + 49'(prody_s1);
		ta2_s2 <= 62'(ta_s1) * 62'(ta_s1);
		tb2_s2 <= 62'(tb_s1) * 62'(tb_s1);
		fa2_s2 <= 62'(fa_s1) * 62'(fa_s1);
		fb2_s2 <= 62'(fb_s1) * 62'(fb_s1);
	end

	// stage 3: reflection terms and sums of squares
	logic signed [64:0] tx_s3, ty_s3;
	logic [62:0]        tsum_s3, fsum_s3;

	always_ff @(posedge clk) begin
		tx_s3   <= 65'(dot_s2) * 65'(carry_q[0].nx);
		ty_s3   <= 65'(dot_s2) * 65'(carry_q[0].ny);
		tsum_s3 <= 63'(ta2_s2) + 63'(tb2_s2);
		fsum_s3 <= 63'(fa2_s2) + 63'(fb2_s2);
	end

	// stage 4: reflected velocity, rounded and saturated
	logic signed [64:0] rtx_c, rty_c;
	logic signed [31:0] nvx_q [NV_N];
	logic signed [31:0] nvy_q [NV_N];
	logic signed [31:0] nvx_s4, nvy_s4;

	always_comb begin
		rtx_c = tx_s3 + 65'sd67108864;
		rty_c = ty_s3 + 65'sd67108864;
	end

	always_ff @(posedge clk) begin
		nvx_s4 <= sat32(40'(carry_q[1].vx) - 40'($signed(rtx_c[64:27])));
		nvy_s4 <= sat32(40'(carry_q[1].vy) - 40'($signed(rty_c[64:27])));
	end

	// velocity waits for the distance path, entry k holds stage k + 5
	always_ff @(posedge clk) begin
		nvx_q[0] <= nvx_s4;
		nvy_q[0] <= nvy_s4;
		for (int k = 1; k < NV_N; k++) begin
			nvx_q[k] <= nvx_q[k-1];
			nvy_q[k] <= nvy_q[k-1];
		end
	end

	// distance roots, results at stage 35
	logic [31:0] troot, froot;

	pwr_isqrt #(.IN_W(64)) u_tsqrt (
		.clk  (clk),
		.din  ({1'b0, tsum_s3}),
		.root (troot)
	);

	pwr_isqrt #(.IN_W(64)) u_fsqrt (
		.clk  (clk),
		.din  ({1'b0, fsum_s3}),
		.root (froot)
	);

	// stage 36: undo the halving of wide differences
	logic [32:0] tnorm_s36, fnorm_s36;

	always_ff @(posedge clk) begin
		tnorm_s36 <= carry_q[33].tsh ? {troot, 1'b0} : {1'b0, troot};
		fnorm_s36 <= carry_q[33].fsh ? {froot, 1'b0} : {1'b0, froot};
	end

	// stage 37: scaled offsets and decisions
	logic [62:0] prodx_s37, prody_s37;
	logic [32:0] tnorm_s37;
	late_t       late_s37;
	late_t       late_q [LATE_N];

	always_ff @(posedge clk) begin
		prodx_s37           <= 63'(carry_q[34].magx) * 63'(carry_q[34].rd);
		prody_s37           <= 63'(carry_q[34].magy) * 63'(carry_q[34].rd);
		tnorm_s37           <= tnorm_s36;
		late_s37.short_move <= ((37'(tnorm_s36) << 3) + (37'(tnorm_s36) << 1)
			< 37'(carry_q[34].rd)) || (tnorm_s36 == '0);
		late_s37.use_ratio  <= (fnorm_s36 != '0) && (tnorm_s36 < fnorm_s36);
	end

	// entry k holds stage k + 38
	always_ff @(posedge clk) begin
		late_q[0] <= late_s37;
		for (int k = 1; k < LATE_N; k++) begin
			late_q[k] <= late_q[k-1];
		end
	end

	// stage 38: add half the norm for rounding
	logic [63:0] numx_s38, numy_s38;
	logic [32:0] tnorm_s38;

	always_ff @(posedge clk) begin
		numx_s38  <= 64'(prodx_s37) + 64'(tnorm_s37[32:1]);
		numy_s38  <= 64'(prody_s37) + 64'(tnorm_s37[32:1]);
		tnorm_s38 <= tnorm_s37;
	end

	// placement offsets, quotients at stage 70
	logic [31:0] offx, offy;

	pwr_div #(.NUM_W(64), .DEN_W(33), .Q_W(32)) u_xdiv (
		.clk (clk),
		.num (numx_s38),
		.den (tnorm_s38),
		.quo (offx)
	);

	pwr_div #(.NUM_W(64), .DEN_W(33), .Q_W(32)) u_ydiv (
		.clk (clk),
		.num (numy_s38),
		.den (tnorm_s38),
		.quo (offy)
	);

	// truncated to full distance ratio at stage 52, its root at stage 68
	logic [15:0] r16;
	logic [15:0] proot;

	pwr_div #(.NUM_W(49), .DEN_W(33), .Q_W(16)) u_rdiv (
		.clk (clk),
		.num ({tnorm_s36, 16'd0}),
		.den (fnorm_s36),
		.quo (r16)
	);

	pwr_isqrt #(.IN_W(32)) u_psqrt (
		.clk  (clk),
		.din  ({r16, 16'd0}),
		.root (proot)
	);

	// stages 69 to 71: step scaling
	logic [16:0]        prop_s69;
	logic signed [49:0] clp_s70;
	logic signed [49:0] clr_c;
	logic signed [31:0] cl_s71, nt_s71;

	always_comb begin
		clr_c = clp_s70 + 50'sd32768;
	end

	always_ff @(posedge clk) begin
		prop_s69 <= late_q[30].use_ratio ? {1'b0, proot} : ONE_Q16;
		clp_s70  <= 50'(carry_q[67].sl) * $signed({33'd0, prop_s69});
		cl_s71   <= sat32(40'($signed(clr_c[49:16])));
		nt_s71   <= sat32(40'(carry_q[68].st) - 40'(carry_q[68].sl)
			+ 40'($signed(clr_c[49:16])));
	end

	// stage 71: placed point
	logic signed [32:0] ox_c, oy_c;
	logic signed [32:0] ox_s71, oy_s71;
	logic signed [33:0] npx_s71, npy_s71;

	always_comb begin
		ox_c = carry_q[68].dxn ? -$signed({1'b0, offx}) : $signed({1'b0, offx});
		oy_c = carry_q[68].dyn ? -$signed({1'b0, offy}) : $signed({1'b0, offy});
	end

	always_ff @(posedge clk) begin
		ox_s71  <= ox_c;
		oy_s71  <= oy_c;
		npx_s71 <= 34'(carry_q[68].hx) + 34'(ox_c);
		npy_s71 <= 34'(carry_q[68].hy) + 34'(oy_c);
	end

	// overshoot past the previous position
	logic signed [34:0] gx_c, gy_c;
	logic               over_c, keep_c;

	always_comb begin
		gx_c   = 35'(carry_q[69].qx) - 35'(npx_s71);
		gy_c   = 35'(carry_q[69].qy) - 35'(npy_s71);
		over_c = (gx_c < 0 && ox_s71 > 0) || (gx_c > 0 && ox_s71 < 0)
			|| (gy_c < 0 && oy_s71 > 0) || (gy_c > 0 && oy_s71 < 0);
		keep_c = late_q[33].short_move || over_c;
	end

	// stage 72: result registers
	always_ff @(posedge clk) begin
		new_pos_x      <= keep_c ? carry_q[69].qx : sat32(40'(npx_s71));
		new_pos_y      <= keep_c ? carry_q[69].qy : sat32(40'(npy_s71));
		new_vel_x      <= nvx_q[NV_N-1];
		new_vel_y      <= nvy_q[NV_N-1];
		new_step_total <= nt_s71;
		new_step_last  <= cl_s71;
	end

endmodule

`default_nettype wire
